### rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque core.
// No dependencies; used by bdq_cell, the top level and the checker.
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;

  // Command codes on in_command
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_PUSH   = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  // Status codes on out_status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_PUSH,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast control to every cell
  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  data;   // new word for append, key for delete
  } cell_ctl_t;

endpackage

### rtl/bdq_cell.sv
// One storage cell of the deque chain: a word and its occupied flag.
// Depends on bdq_pkg.
module bdq_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdq_pkg::cell_ctl_t                ctl,
  input  logic signed [bdq_pkg::DATA_W-1:0] head_val,
  input  logic signed [bdq_pkg::DATA_W-1:0] left_val,
  input  logic                              left_occ,
  input  logic signed [bdq_pkg::DATA_W-1:0] right_val,
  input  logic                              right_occ,
  input  logic                              hit_in,
  output logic signed [bdq_pkg::DATA_W-1:0] val,
  output logic                              occ,
  output logic                              hit_out
);

  logic signed [bdq_pkg::DATA_W-1:0] val_r;
  logic                              occ_r;
  logic                              hit;

  // first match at or before this cell
  assign hit     = hit_in | (occ_r && (val_r == ctl.data));
  assign hit_out = hit;
  assign val     = val_r;
  assign occ     = occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      case (ctl.op)
        bdq_pkg::CELL_APPEND: begin
          if (!occ_r && left_occ) begin
            val_r <= ctl.data;
            occ_r <= 1'b1;
          end
        end
        bdq_pkg::CELL_PUSH: begin
          val_r <= left_val;
          occ_r <= left_occ;
        end
        bdq_pkg::CELL_DELETE: begin
          if (hit) begin
            val_r <= right_val;
            occ_r <= right_occ;
          end
        end
        bdq_pkg::CELL_ROTATE: begin
          if (occ_r) begin
            val_r <= right_occ ? right_val : head_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/bounded_deque_with_delete_core.sv
// Append/push answer in the cycle after accept; delete passes through S_DEL, and
//   a non-empty list through S_LIST, before the result is registered. A list then
//   gives a word per cycle unless out_stall, count words in all. One command at a
//   time; a list holds the input to its last word, rotating one place per word.
// Reset (rst_n low, synchronous): count, occupied flags and handshake state clear;
//   stored words are left as they are. No clearing pass.
module bounded_deque_with_delete_core #(
  parameter int CAPACITY = bdq_pkg::CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_item_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bdq_pkg::DATA_W-1:0] out_value,
  output logic [1:0]                        out_status,
  output logic                              out_last
);

  localparam int CW = $clog2(CAPACITY + 1);  // entry count
  localparam int RW = $clog2(CAPACITY);      // words left in a listing

  typedef enum logic [1:0] {S_IDLE, S_DEL, S_LIST} state_t;

  state_t                            state_r;
  logic [CW-1:0]                     cnt_r;
  logic [RW-1:0]                     rem_r;
  logic signed [bdq_pkg::DATA_W-1:0] key_r;
  logic                              out_valid_r;
  logic signed [bdq_pkg::DATA_W-1:0] out_value_r;
  logic [1:0]                        out_status_r;
  logic                              out_last_r;

  logic                              out_free;
  logic                              in_acc;
  logic                              full;
  logic                              found;
  bdq_pkg::cell_ctl_t                ctl;

  // chain wiring: cell 0 is the head
  logic signed [bdq_pkg::DATA_W-1:0] val_w [CAPACITY];
  logic                              occ_w [CAPACITY];
  logic                              hit_w [CAPACITY+1];

  // the output word slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (cnt_r == CW'(CAPACITY));
  assign found    = hit_w[CAPACITY];
  assign hit_w[0] = 1'b0;

  always_comb begin
    ctl.op   = bdq_pkg::CELL_HOLD;
    ctl.data = in_item_value;
    case (state_r)
      S_IDLE: begin
        if (in_acc && !full) begin
          if (in_command == bdq_pkg::CMD_APPEND) ctl.op = bdq_pkg::CELL_APPEND;
          if (in_command == bdq_pkg::CMD_PUSH)   ctl.op = bdq_pkg::CELL_PUSH;
        end
      end
      S_DEL: begin
        ctl.data = key_r;
        if (out_free) ctl.op = bdq_pkg::CELL_DELETE;
      end
      S_LIST: begin
        // rotate left one place per emitted word; head wraps to the tail
        if (out_free) ctl.op = bdq_pkg::CELL_ROTATE;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [bdq_pkg::DATA_W-1:0] lv;
    logic                              lo;
    logic signed [bdq_pkg::DATA_W-1:0] rv;
    logic                              ro;

    if (i == 0) begin : g_head
      assign lv = in_item_value;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = val_w[i-1];
      assign lo = occ_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv = val_w[i];
      assign ro = 1'b0;
    end else begin : g_body
      assign rv = val_w[i+1];
      assign ro = occ_w[i+1];
    end

    bdq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .head_val  (val_w[0]),
      .left_val  (lv),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .hit_in    (hit_w[i]),
      .val       (val_w[i]),
      .occ       (occ_w[i]),
      .hit_out   (hit_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_command)
              bdq_pkg::CMD_APPEND, bdq_pkg::CMD_PUSH: begin
                out_valid_r  <= 1'b1;
                out_value_r  <= '0;
                out_last_r   <= 1'b1;
                out_status_r <= full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
                if (!full) cnt_r <= cnt_r + 1'b1;
              end
              bdq_pkg::CMD_DELETE: begin
                key_r   <= in_item_value;
                state_r <= S_DEL;
              end
              default: begin
                // list
                if (cnt_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_value_r  <= '0;
                  out_last_r   <= 1'b1;
                  out_status_r <= bdq_pkg::ST_EMPTY;
                end else begin
                  rem_r   <= RW'(cnt_r - 1'b1);
                  state_r <= S_LIST;
                end
              end
            endcase
          end
        end
        S_DEL: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= '0;
            out_last_r   <= 1'b1;
            out_status_r <= found ? bdq_pkg::ST_OK : bdq_pkg::ST_NOT_FOUND;
            if (found) cnt_r <= cnt_r - 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_LIST: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= val_w[0];
            out_status_r <= bdq_pkg::ST_OK;
            out_last_r   <= (rem_r == '0);
            if (rem_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              rem_r <= rem_r - 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

### rtl/bdq_checker.sv
// Port-level checks for bounded_deque_with_delete_core, attached by bind.
// Depends on bdq_pkg.
module bdq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        in_command,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bdq_pkg::DATA_W-1:0] out_value,
  input logic [1:0]                        out_status,
  input logic                              out_last
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(out_status) && $stable(out_last))
    else $error("stalled result word changed");

  // any non-ok status is a single zero-valued word
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bdq_pkg::ST_OK) |-> (out_value == '0) && out_last)
    else $error("status word malformed");

  // a delete needs a search state, so the input is busy right after it
  a_del_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == bdq_pkg::CMD_DELETE) |=> in_stall)
    else $error("input taken during delete search");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounded_deque_with_delete_core bdq_checker u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_value  (out_value),
  .out_status (out_status),
  .out_last   (out_last)
);
